// ----- design/atsr_pkg.sv -----
`timescale 1ns / 1ps
package atsr_pkg;
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_MAX_SEG = 2'd1,
        REG_LIFE    = 2'd2,
        REG_MIN_D   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_DCMP,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_EMIT_RD,
        ST_EMIT_DIV,
        ST_EMIT_OUT,
        ST_EMPTY_OUT
    } state_t;

    localparam logic [31:0] MIN_LIFE = 32'd66;

    // request into the divider
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;

    // squared magnitude of a signed difference, saturated at 2^64-1
    function automatic logic [63:0] sq_sat(input logic [32:0] d);
        logic [32:0] ad;
        logic [63:0] r;
        begin
            ad = d[32] ? (~d + 33'd1) : d;
            if (ad[32]) r = '1;
            else r = 64'(ad[31:0] * ad[31:0]);
            return r;
        end
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        end
    endfunction
endpackage

// ----- design/atsr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 48-bit numerator
module atsr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  atsr_pkg::div_req_t req,
    output atsr_pkg::div_rsp_t rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[47]};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one numerator bit, subtract when it fits
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ----- design/atsr_store.sv -----
`timescale 1ns / 1ps
// Pair memory: six coordinates plus age per slot, registered read
module atsr_store #(
    parameter int SLOT_W = 5
) (
    input  logic              aclk,
    input  logic              wr_coord,
    input  logic              wr_age,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [191:0]      wr_coords,
    input  logic [31:0]       wr_agev,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic [191:0]      rd_coords,
    output logic [31:0]       rd_age
);
    localparam int DEPTH = 1 << SLOT_W;
    logic [191:0] coord_mem [DEPTH];
    logic [31:0]  age_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_coord) coord_mem[wr_slot] <= wr_coords;
        rd_coords <= coord_mem[rd_slot];
    end

    always_ff @(posedge aclk) begin
        if (wr_age) age_mem[wr_slot] <= wr_agev;
        rd_age <= age_mem[rd_slot];
    end
endmodule

// ----- design/aging_trail_sample_ring_unit.sv -----
`timescale 1ns / 1ps
// Trail sample ring. Requests enter on s_valid/s_ready with an opcode:
// push stores a base/tip pair, update ages all pairs and emits them on
// m_valid/m_ready from oldest to newest, clear empties the ring.
// One request is worked at a time; s_ready is high only when idle.
// Push computes the distance squares, then compares them. Update ages
// each stored pair with a read and a write, drops expired pairs from
// the front, and for each emitted pair does a memory read plus two
// divider passes (u, alpha); the shared serial divider sets the rate.
// With fewer than two pairs an update emits one result marked invalid.
// Each result waits in the output register until m_ready; the engine
// stalls once the next result is ready. Reset empties the ring and
// loads the register defaults; the pair memory is not cleared, only
// the counts are. Registers on APB: enable 0x0, max_segments 0x4,
// life_time 0x8, min_distance 0xC. pready is always high.
module aging_trail_sample_ring_unit #(
    parameter int MAX_PAIRS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_base_x,
    input  logic signed [31:0] s_base_y,
    input  logic signed [31:0] s_base_z,
    input  logic signed [31:0] s_tip_x,
    input  logic signed [31:0] s_tip_y,
    input  logic signed [31:0] s_tip_z,
    input  logic [31:0]        s_delta_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_base_x,
    output logic signed [31:0] m_out_base_y,
    output logic signed [31:0] m_out_base_z,
    output logic signed [31:0] m_out_tip_x,
    output logic signed [31:0] m_out_tip_y,
    output logic signed [31:0] m_out_tip_z,
    output logic [16:0]        m_u_coord,
    output logic [16:0]        m_alpha,
    output logic               m_pair_valid,
    output logic               m_last
);
    localparam int SLOT_W = (MAX_PAIRS > 32) ? 6 : $clog2(MAX_PAIRS);
    localparam int DEPTH  = 1 << SLOT_W;
    localparam int CNT_W  = SLOT_W + 1;

    // configuration registers
    logic        enable_reg;
    logic [4:0]  max_seg_reg;
    logic [31:0] life_reg;
    logic [30:0] min_d_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b1;
            max_seg_reg <= 5'd31;
            life_reg    <= 32'd65536;
            min_d_reg   <= '0;
        end else if (cfg_wr) begin
            case (atsr_pkg::reg_idx_t'(cfg_idx))
                atsr_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                atsr_pkg::REG_MAX_SEG: max_seg_reg <= pwdata[4:0];
                atsr_pkg::REG_LIFE:    life_reg    <= pwdata;
                atsr_pkg::REG_MIN_D:   min_d_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (atsr_pkg::reg_idx_t'(cfg_idx))
            atsr_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            atsr_pkg::REG_MAX_SEG: prdata = {27'd0, max_seg_reg};
            atsr_pkg::REG_LIFE:    prdata = life_reg;
            atsr_pkg::REG_MIN_D:   prdata = {1'b0, min_d_reg};
            default:               prdata = '0;
        endcase
    end

    // derived constants
    logic [31:0]      life_eff;
    logic [CNT_W-1:0] cap;
    logic [5:0]       seg_p1;
    assign life_eff = (life_reg < atsr_pkg::MIN_LIFE) ? atsr_pkg::MIN_LIFE : life_reg;
    assign seg_p1   = ((max_seg_reg == 5'd0) ? 6'd1 : {1'b0, max_seg_reg}) + 6'd1;
    assign cap      = ({1'b0, seg_p1} > 7'(MAX_PAIRS)) ? CNT_W'(MAX_PAIRS) : CNT_W'(seg_p1);

    // ring control state
    atsr_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              have_last_reg, have_last_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              phase_reg, phase_next;

    // request payload
    logic [191:0]      pt_reg, pt_next;
    logic [31:0]       dt_reg, dt_next;
    logic [191:0]      last_pt_reg, last_pt_next;
    logic [63:0]       db_reg, db_next, dtp_reg, dtp_next;
    logic [16:0]       u_reg, u_next;
    logic [16:0]       a_reg, a_next;

    // output register
    logic         m_valid_reg, m_valid_next;
    logic [191:0] o_pts_reg, o_pts_next;
    logic [16:0]  o_u_reg, o_u_next, o_a_reg, o_a_next;
    logic         o_pv_reg, o_pv_next, o_last_reg, o_last_next;

    // memory
    logic              wr_coord, wr_age;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic [191:0]      wr_coords, rd_coords;
    logic [31:0]       wr_agev, rd_age;

    atsr_pkg::div_req_t dreq;
    atsr_pkg::div_rsp_t drsp;

    atsr_store #(.SLOT_W(SLOT_W)) u_store (
        .aclk, .wr_coord, .wr_age, .wr_slot, .wr_coords, .wr_agev,
        .rd_slot, .rd_coords, .rd_age
    );

    atsr_div u_div (.aclk, .aresetn, .req(dreq), .rsp(drsp));

    logic s_acc, m_acc;
    assign s_acc   = s_valid & s_ready;
    assign m_acc   = m_valid_reg & m_ready;
    assign s_ready = (state_reg == atsr_pkg::ST_IDLE);

    logic [SLOT_W-1:0] idx_slot, tail_slot;
    logic [32:0]       age_sum;
    logic [63:0]       db_c, dt_c, mx, md2;
    logic [CNT_W-1:0]  n_m1;
    logic [47:0]       qa;

    always_comb begin
        idx_slot  = SLOT_W'(oldest_reg + SLOT_W'(idx_reg));
        tail_slot = SLOT_W'(oldest_reg + SLOT_W'(count_reg));
        age_sum   = {1'b0, rd_age} + {1'b0, dt_reg};
        n_m1      = count_reg - CNT_W'(1);
        db_c = atsr_pkg::add_sat(atsr_pkg::add_sat(
            atsr_pkg::sq_sat({pt_reg[31], pt_reg[31:0]} - {last_pt_reg[31], last_pt_reg[31:0]}),
            atsr_pkg::sq_sat({pt_reg[63], pt_reg[63:32]} - {last_pt_reg[63], last_pt_reg[63:32]})),
            atsr_pkg::sq_sat({pt_reg[95], pt_reg[95:64]} - {last_pt_reg[95], last_pt_reg[95:64]}));
        dt_c = atsr_pkg::add_sat(atsr_pkg::add_sat(
            atsr_pkg::sq_sat({pt_reg[127], pt_reg[127:96]} - {last_pt_reg[127], last_pt_reg[127:96]}),
            atsr_pkg::sq_sat({pt_reg[159], pt_reg[159:128]} - {last_pt_reg[159], last_pt_reg[159:128]})),
            atsr_pkg::sq_sat({pt_reg[191], pt_reg[191:160]} - {last_pt_reg[191], last_pt_reg[191:160]}));
        mx  = (db_reg > dtp_reg) ? db_reg : dtp_reg;
        md2 = 64'(min_d_reg * min_d_reg);
        qa  = drsp.quo;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        have_last_next = have_last_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        pt_next        = pt_reg;
        dt_next        = dt_reg;
        last_pt_next   = last_pt_reg;
        db_next        = db_reg;
        dtp_next       = dtp_reg;
        u_next         = u_reg;
        a_next         = a_reg;
        m_valid_next   = m_valid_reg & ~m_acc;
        o_pts_next     = o_pts_reg;
        o_u_next       = o_u_reg;
        o_a_next       = o_a_reg;
        o_pv_next      = o_pv_reg;
        o_last_next    = o_last_reg;
        wr_coord       = 1'b0;
        wr_age         = 1'b0;
        wr_slot        = idx_slot;
        wr_coords      = pt_reg;
        wr_agev        = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
        rd_slot        = idx_slot;
        dreq.start     = 1'b0;
        dreq.num       = '0;
        dreq.den       = life_eff;

        case (state_reg)
            atsr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    pt_next = {s_tip_z, s_tip_y, s_tip_x, s_base_z, s_base_y, s_base_x};
                    dt_next = s_delta_time;
                    idx_next = '0;
                    case (atsr_pkg::opcode_t'(s_opcode))
                        atsr_pkg::OP_CLEAR: begin
                            oldest_next    = '0;
                            count_next     = '0;
                            have_last_next = 1'b0;
                        end
                        atsr_pkg::OP_PUSH:
                            if (enable_reg) state_next = atsr_pkg::ST_DIST;
                        atsr_pkg::OP_UPDATE:
                            if (enable_reg) state_next = atsr_pkg::ST_AGE_RD;
                        default: ;
                    endcase
                end
            end
            atsr_pkg::ST_DIST: begin
                db_next    = db_c;
                dtp_next   = dt_c;
                state_next = atsr_pkg::ST_DCMP;
            end
            atsr_pkg::ST_DCMP: begin
                state_next = atsr_pkg::ST_IDLE;
                if (!have_last_reg || !(mx < md2)) begin
                    last_pt_next   = pt_reg;
                    have_last_next = 1'b1;
                    // new pair goes right after the newest one
                    wr_slot = tail_slot;
                    // a full ring gives up its oldest pairs
                    if (count_reg >= cap) begin
                        oldest_next = SLOT_W'(oldest_reg + SLOT_W'(count_reg - cap + CNT_W'(1)));
                        count_next  = cap;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    wr_coord = 1'b1;
                    wr_age   = 1'b1;
                    wr_agev  = '0;
                end
            end
            atsr_pkg::ST_AGE_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = atsr_pkg::ST_EXP_RD;
                end else begin
                    state_next = atsr_pkg::ST_AGE_WR;
                end
            end
            atsr_pkg::ST_AGE_WR: begin
                wr_age     = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = atsr_pkg::ST_AGE_RD;
            end
            // drop expired pairs at the front
            atsr_pkg::ST_EXP_RD: begin
                rd_slot = oldest_reg;
                if (count_reg == '0) state_next = atsr_pkg::ST_EMPTY_OUT;
                else state_next = atsr_pkg::ST_EXP_CHK;
            end
            atsr_pkg::ST_EXP_CHK: begin
                if (rd_age >= life_eff) begin
                    oldest_next = SLOT_W'(oldest_reg + SLOT_W'(1));
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = atsr_pkg::ST_EXP_RD;
                end else begin
                    idx_next   = '0;
                    state_next = (count_reg < CNT_W'(2)) ? atsr_pkg::ST_EMPTY_OUT
                                                         : atsr_pkg::ST_EMIT_RD;
                end
            end
            atsr_pkg::ST_EMPTY_OUT: begin
                if (!m_valid_reg || m_acc) begin
                    m_valid_next = 1'b1;
                    o_pts_next   = '0;
                    o_u_next     = '0;
                    o_a_next     = '0;
                    o_pv_next    = 1'b0;
                    o_last_next  = 1'b1;
                    state_next   = atsr_pkg::ST_IDLE;
                end
            end
            atsr_pkg::ST_EMIT_RD: begin
                // u = round(i*65536/(n-1))
                dreq.start = 1'b1;
                dreq.num   = 48'({idx_reg, 16'd0}) + 48'(n_m1 >> 1);
                dreq.den   = 32'(n_m1);
                phase_next = 1'b0;
                state_next = atsr_pkg::ST_EMIT_DIV;
            end
            atsr_pkg::ST_EMIT_DIV: begin
                if (drsp.done) begin
                    if (!phase_reg) begin
                        u_next     = qa[16:0];
                        dreq.start = 1'b1;
                        dreq.num   = {rd_age, 16'd0} + 48'(life_eff >> 1);
                        phase_next = 1'b1;
                    end else begin
                        state_next = atsr_pkg::ST_EMIT_OUT;
                        a_next     = (qa >= 48'd65536) ? 17'd0 : 17'(48'd65536 - qa);
                    end
                end
            end
            atsr_pkg::ST_EMIT_OUT: begin
                if (!m_valid_reg || m_acc) begin
                    m_valid_next = 1'b1;
                    o_pts_next   = rd_coords;
                    o_u_next     = u_reg;
                    o_a_next     = a_reg;
                    o_pv_next    = 1'b1;
                    o_last_next  = (idx_reg == n_m1);
                    idx_next     = idx_reg + CNT_W'(1);
                    state_next   = (idx_reg == n_m1) ? atsr_pkg::ST_IDLE
                                                     : atsr_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = atsr_pkg::ST_IDLE;
        endcase
    end

    // rd_age/rd_coords stay valid through the divide since rd_slot is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= atsr_pkg::ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            have_last_reg <= have_last_next;
            m_valid_reg   <= m_valid_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
        end
        pt_reg      <= pt_next;
        dt_reg      <= dt_next;
        last_pt_reg <= last_pt_next;
        db_reg      <= db_next;
        dtp_reg     <= dtp_next;
        u_reg       <= u_next;
        a_reg       <= a_next;
        o_pts_reg   <= o_pts_next;
        o_u_reg     <= o_u_next;
        o_a_reg     <= o_a_next;
        o_pv_reg    <= o_pv_next;
        o_last_reg  <= o_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_base_x = o_pts_reg[31:0];
    assign m_out_base_y = o_pts_reg[63:32];
    assign m_out_base_z = o_pts_reg[95:64];
    assign m_out_tip_x  = o_pts_reg[127:96];
    assign m_out_tip_y  = o_pts_reg[159:128];
    assign m_out_tip_z  = o_pts_reg[191:160];
    assign m_u_coord    = o_u_reg;
    assign m_alpha      = o_a_reg;
    assign m_pair_valid = o_pv_reg;
    assign m_last       = o_last_reg;

    // ring never holds more than the memory depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("pair count exceeds ring depth");

    // a held result does not change while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(o_pts_reg) && $stable(o_last_reg))
        else $error("result changed while stalled");

    // an invalid result is always the last of its update
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pair_valid |-> m_last)
        else $error("invalid result not marked last");

    // no request taken while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != atsr_pkg::ST_IDLE |-> !s_ready)
        else $error("ready while busy");
endmodule
